// ===== rtl/core/srg_pkg.sv =====
package srg_pkg;

  localparam int unsigned WordW  = 30;
  localparam int unsigned SeedW  = 31;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned TabLen = 55;
  localparam int unsigned RamDepth = TabLen + 1;

  localparam logic [WordW-1:0] ModBig    = 30'd1000000000;
  localparam logic [SeedW-1:0] SeedMagic = 31'd161803398;
  // SeedMagic + ModBig, used to fold |magic - seed| back below the modulus
  localparam logic [SeedW-1:0] SeedMagicHi = 31'd1161803398;

  localparam logic [AddrW-1:0] LastIdx  = 6'd55;
  localparam logic [AddrW-1:0] LagStart = 6'd31;
  localparam logic [AddrW-1:0] Stride   = 6'd21;

  typedef logic [WordW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;

  // a - b modulo 1e9, both operands already below the modulus
  function automatic word_t sub_mod(input word_t a, input word_t b);
    word_t d;
    begin
      d = a - b;
      if (a < b) begin
        d = d + ModBig;
      end
      return d;
    end
  endfunction

endpackage

// ===== rtl/core/srg_ram.sv =====
module srg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/subtractive_random_generator.sv =====
// Subtractive lagged random generator (55-word table, lags 55/24). Each request
// returns one integer in 0..999999999; value/1e9 is the uniform fraction. An
// ordinary draw reads both lag entries from the two-read-port table RAM, then
// subtracts, writes back and loads the output register (waiting while that
// register still holds an unaccepted result), and then returns to idle. A
// request with reseed set, and the first request after reset, first seeds the
// table: 55 fill writes and 4 x 55 mixing steps, each a read and then a
// subtract and write. The seed register is taken only when seeding starts. A
// finished result waits in the output register; a new request is accepted
// while it waits.
module subtractive_random_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [30:0] seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        reseed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] value
);

  typedef enum logic [2:0] {
    IDLE,
    FILL,
    MIX_RD,
    MIX_WR,
    DRAW_RD,
    DRAW_WR
  } state_t;

  state_t               state;
  logic [30:0]          seed_held;
  srg_pkg::word_t       cur;
  srg_pkg::word_t       prev;
  srg_pkg::addr_t       pos;
  srg_pkg::addr_t       idx;
  logic [1:0]           pass;
  srg_pkg::addr_t       fp;
  srg_pkg::addr_t       sp;
  logic                 seeded;

  srg_pkg::word_t       cur_start;
  srg_pkg::addr_t       pos_next;
  logic [6:0]           pos_sum;
  srg_pkg::addr_t       fp_inc;
  srg_pkg::addr_t       sp_inc;
  srg_pkg::addr_t       mix_lag;
  srg_pkg::addr_t       raddr_a;
  srg_pkg::addr_t       raddr_b;
  srg_pkg::word_t       rdata_a;
  srg_pkg::word_t       rdata_b;
  srg_pkg::word_t       diff;
  logic                 we;
  srg_pkg::addr_t       waddr;
  srg_pkg::word_t       wdata;
  logic                 slot_free;

  // |magic - seed| mod 1e9 in one level of parallel subtracts
  always_comb begin
    logic [30:0] d;
    d = '0;
    if (seed_held <= srg_pkg::SeedMagic) begin
      d = srg_pkg::SeedMagic - seed_held;
    end else if (seed_held >= srg_pkg::SeedMagicHi) begin
      d = seed_held - srg_pkg::SeedMagicHi;
    end else begin
      d = seed_held - srg_pkg::SeedMagic;
    end
    cur_start = d[29:0];
  end

  assign pos_sum  = {1'b0, pos} + {1'b0, srg_pkg::Stride};
  assign pos_next = (pos_sum >= 7'(srg_pkg::TabLen)) ?
                    6'(pos_sum - 7'(srg_pkg::TabLen)) : pos_sum[5:0];

  assign fp_inc  = (fp == srg_pkg::LastIdx) ? 6'd1 : fp + 6'd1;
  assign sp_inc  = (sp == srg_pkg::LastIdx) ? 6'd1 : sp + 6'd1;
  assign mix_lag = (idx <= 6'd24) ? idx + 6'd31 : idx - 6'd24;

  assign raddr_a = (state == MIX_RD || state == MIX_WR) ? idx : fp_inc;
  assign raddr_b = (state == MIX_RD || state == MIX_WR) ? mix_lag : sp_inc;

  assign diff      = srg_pkg::sub_mod(rdata_a, rdata_b);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = diff;
    unique case (state)
      FILL: begin
        we    = 1'b1;
        waddr = pos;
        wdata = (pos == srg_pkg::LastIdx) ? cur : prev;
      end
      MIX_WR: begin
        we = 1'b1;
      end
      DRAW_WR: begin
        we    = slot_free;
        waddr = fp_inc;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  srg_ram #(
    .Width(srg_pkg::WordW),
    .Depth(srg_pkg::RamDepth)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      seed_held <= '0;
      fp        <= '0;
      sp        <= srg_pkg::LagStart;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      pass      <= '0;
    end else begin
      if (seed_we) begin
        seed_held <= seed;
      end
      if (out_valid && out_ready && state != DRAW_WR) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            if (reseed || !seeded) begin
              cur   <= cur_start;
              prev  <= 30'd1;
              pos   <= srg_pkg::LastIdx;
              idx   <= '0;
              state <= FILL;
            end else begin
              state <= DRAW_RD;
            end
          end
        end
        FILL: begin
          if (pos != srg_pkg::LastIdx) begin
            prev <= srg_pkg::sub_mod(cur, prev);
            cur  <= prev;
          end
          pos <= pos_next;
          if (idx == 6'd54) begin
            idx   <= 6'd1;
            pass  <= '0;
            state <= MIX_RD;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        MIX_RD: begin
          state <= MIX_WR;
        end
        MIX_WR: begin
          if (idx == srg_pkg::LastIdx) begin
            idx  <= 6'd1;
            pass <= pass + 2'd1;
            if (pass == 2'd3) begin
              fp     <= '0;
              sp     <= srg_pkg::LagStart;
              seeded <= 1'b1;
              state  <= DRAW_RD;
            end else begin
              state <= MIX_RD;
            end
          end else begin
            idx   <= idx + 6'd1;
            state <= MIX_RD;
          end
        end
        DRAW_RD: begin
          state <= DRAW_WR;
        end
        DRAW_WR: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            value     <= diff;
            fp        <= fp_inc;
            sp        <= sp_inc;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/srg_checker.sv =====
module srg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] value
);

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value < srg_pkg::ModBig))
    else $error("result value not below 1e9");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready still high right after a request");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a draw in progress");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value)))
    else $error("stalled result dropped or changed");

endmodule

bind subtractive_random_generator srg_checker u_srg_checker (.*);
